@@ design/mata_pkg.sv @@
// Package for the multichannel aggregate threshold alarm.
// Holds mode and register codes, channel count and controller/datapath structs.
// No dependencies.
package mata_pkg;

    localparam int CHANNELS        = 8;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int THR_BITS        = 32;
    localparam int CFG_DATA_BITS   = 32;
    localparam int NUM_VALUES_BITS = 4;
    localparam int DIV_RADIX_BITS  = 4;

    typedef enum logic [2:0] {
        AGG_ANY = 3'd0,
        AGG_ALL = 3'd1,
        AGG_SUM = 3'd2,
        AGG_AVG = 3'd3,
        AGG_MAX = 3'd4,
        AGG_MIN = 3'd5
    } agg_mode_t;

    typedef enum logic [2:0] {
        CMP_EQ = 3'd0,
        CMP_NE = 3'd1,
        CMP_LT = 3'd2,
        CMP_GT = 3'd3,
        CMP_LE = 3'd4,
        CMP_GE = 3'd5
    } cmp_mode_t;

    typedef enum logic [1:0] {
        REG_AGG_MODE  = 2'd0,
        REG_CMP_MODE  = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_CHAN_MASK = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic div_load;
        logic div_step;
        logic finish;
    } mata_cmd_t;

    typedef struct packed {
        logic need_div;
    } mata_stat_t;

endpackage

@@ design/multichannel_aggregate_threshold_alarm_core.sv @@
// An accepted request steps through the channel scan, the divider operand load, the divide (only
// in average mode with a non-empty pick; the divider retires 4 quotient bits a cycle) and
// finish; in_stall holds off a new request until the core is back in idle. The scan takes
// one channel a cycle. Reset clears the config registers, the alarm latch and handshake
// state; no memory clearing pass. Depends on mata_pkg, mata_ctrl and mata_dp.
module multichannel_aggregate_threshold_alarm_core
    import mata_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [1:0]                            cfg_index,
    input  logic [CFG_DATA_BITS-1:0]              cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample_0,
    input  logic signed [SAMPLE_BITS-1:0]         sample_1,
    input  logic signed [SAMPLE_BITS-1:0]         sample_2,
    input  logic signed [SAMPLE_BITS-1:0]         sample_3,
    input  logic signed [SAMPLE_BITS-1:0]         sample_4,
    input  logic signed [SAMPLE_BITS-1:0]         sample_5,
    input  logic signed [SAMPLE_BITS-1:0]         sample_6,
    input  logic signed [SAMPLE_BITS-1:0]         sample_7,
    input  logic [NUM_VALUES_BITS-1:0]            num_values,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  alarm_fire,
    output logic                                  condition,
    output logic signed [SAMPLE_BITS+$clog2(CHANNELS)-1:0] aggregate_value
);

    logic signed [SAMPLE_BITS-1:0] samples [CHANNELS];
    mata_cmd_t                     cmd;
    mata_stat_t                    stat;

    assign samples[0] = sample_0;
    assign samples[1] = sample_1;
    assign samples[2] = sample_2;
    assign samples[3] = sample_3;
    assign samples[4] = sample_4;
    assign samples[5] = sample_5;
    assign samples[6] = sample_6;
    assign samples[7] = sample_7;

    mata_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mata_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .samples         (samples),
        .num_values      (num_values),
        .cmd             (cmd),
        .stat            (stat),
        .alarm_fire      (alarm_fire),
        .condition       (condition),
        .aggregate_value (aggregate_value)
    );

endmodule

@@ design/mata_ctrl.sv @@
// Controller for the alarm core: sequences load, channel scan, divide and finish.
// Depends on mata_pkg; drives the datapath through mata_cmd_t.
module mata_ctrl
    import mata_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  mata_stat_t stat,
    output mata_cmd_t  cmd
);

    localparam int AGG_W     = SAMPLE_BITS + $clog2(CHANNELS);
    localparam int DIV_STEPS = (AGG_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int MAX_STEPS = (DIV_STEPS > CHANNELS) ? DIV_STEPS : CHANNELS;
    localparam int STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DIVLD = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = STEP_W'(CHANNELS - 1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (step_reg == '0)
                    state_next = ST_DIVLD;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_DIVLD:
            begin
                cmd.div_load = 1'b1;
                if (stat.need_div)
                begin
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_FIN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                    state_next = ST_FIN;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start the channel scan");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finish did not present a result");

    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ($past(state_reg) == ST_DIVLD || $past(state_reg) == ST_DIV))
        else $error("divide entered without operand load");

endmodule

@@ design/mata_dp.sv @@
// Datapath for the alarm core: config registers, channel scan, radix-16 divider,
// result registers and the alarm latch. Depends on mata_pkg; driven by mata_ctrl.
module mata_dp
    import mata_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [1:0]                            cfg_index,
    input  logic [CFG_DATA_BITS-1:0]              cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]         samples [CHANNELS],
    input  logic [NUM_VALUES_BITS-1:0]            num_values,
    input  mata_cmd_t                             cmd,
    output mata_stat_t                            stat,
    output logic                                  alarm_fire,
    output logic                                  condition,
    output logic signed [SAMPLE_BITS+$clog2(CHANNELS)-1:0] aggregate_value
);

    localparam int AGG_W     = SAMPLE_BITS + $clog2(CHANNELS);
    localparam int CMP_W     = (AGG_W > THR_BITS) ? AGG_W : THR_BITS;
    localparam int CNT_W     = $clog2(CHANNELS + 1);
    localparam int DIV_STEPS = (AGG_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int Q_W       = DIV_STEPS * DIV_RADIX_BITS;

    agg_mode_t                    agg_mode_reg;
    cmp_mode_t                    cmp_mode_reg;
    logic signed [THR_BITS-1:0]   threshold_reg;
    logic [CHANNELS-1:0]          chan_mask_reg;
    logic                         alarm_latched_reg;
    logic                         alarm_latched_next;

    logic signed [SAMPLE_BITS-1:0] samp_reg [CHANNELS];
    logic [CHANNELS-1:0]           pick_reg;
    logic                          any_reg;
    logic                          all_reg;
    logic                          first_reg;
    logic signed [AGG_W-1:0]       sum_reg;
    logic signed [SAMPLE_BITS-1:0] ext_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [Q_W-1:0]                quo_reg;
    logic [Q_W-1:0]                quo_next;
    logic [CNT_W-1:0]              rem_reg;
    logic [CNT_W-1:0]              rem_next;
    logic                          neg_reg;

    logic                          alarm_fire_reg;
    logic                          condition_reg;
    logic signed [AGG_W-1:0]       aggregate_value_reg;

    logic signed [SAMPLE_BITS-1:0] tap;
    logic                          tap_pick;
    logic                          tap_pass;
    logic                          tap_better;
    logic [AGG_W-1:0]              sum_mag;
    logic signed [AGG_W-1:0]       quo_signed;
    logic signed [AGG_W-1:0]       agg_val;
    logic                          cond;

    function automatic logic rel(input cmp_mode_t mode, input logic signed [CMP_W-1:0] a,
                                 input logic signed [CMP_W-1:0] t);
        logic r;
        unique case (mode)
            CMP_EQ:  r = (a == t);
            CMP_NE:  r = (a != t);
            CMP_LT:  r = (a < t);
            CMP_GT:  r = (a > t);
            CMP_LE:  r = (a <= t);
            CMP_GE:  r = (a >= t);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agg_mode_reg  <= AGG_ANY;
            cmp_mode_reg  <= CMP_EQ;
            threshold_reg <= '0;
            chan_mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_AGG_MODE:  agg_mode_reg  <= agg_mode_t'(cfg_data[2:0]);
                REG_CMP_MODE:  cmp_mode_reg  <= cmp_mode_t'(cfg_data[2:0]);
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_BITS-1:0];
                REG_CHAN_MASK: chan_mask_reg <= cfg_data[CHANNELS-1:0];
                default:       chan_mask_reg <= chan_mask_reg;
            endcase
        end
    end

    // scan tap
    assign tap        = samp_reg[0];
    assign tap_pick   = pick_reg[0];
    assign tap_pass   = rel(cmp_mode_reg, CMP_W'(tap), CMP_W'(threshold_reg));
    assign tap_better = (agg_mode_reg == AGG_MAX) ? (tap > ext_reg) : (tap < ext_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int n = 0; n < CHANNELS; n++)
            begin
                samp_reg[n] <= samples[n];
                pick_reg[n] <= chan_mask_reg[n] && (n < int'(num_values));
            end
            any_reg   <= 1'b0;
            all_reg   <= 1'b1;
            first_reg <= 1'b1;
            sum_reg   <= '0;
            ext_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.scan)
        begin
            for (int n = 0; n < CHANNELS - 1; n++)
            begin
                samp_reg[n] <= samp_reg[n+1];
                pick_reg[n] <= pick_reg[n+1];
            end
            pick_reg[CHANNELS-1] <= 1'b0;
            if (tap_pick)
            begin
                any_reg <= any_reg | tap_pass;
                all_reg <= all_reg & tap_pass;
                sum_reg <= sum_reg + AGG_W'(tap);
                cnt_reg <= cnt_reg + 1'b1;
                if (first_reg || tap_better)
                    ext_reg <= tap;
                first_reg <= 1'b0;
            end
        end
    end

    // signed divide by pick count: magnitude, radix-16 restoring steps, sign fix
    assign sum_mag = sum_reg[AGG_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    always_comb
    begin
        logic [CNT_W-1:0] r;
        logic [Q_W-1:0]   q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            r = {r[CNT_W-2:0], q[Q_W-1]};
            q = {q[Q_W-2:0], 1'b0};
            if (r >= cnt_reg)
            begin
                r    = r - cnt_reg;
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg <= Q_W'(sum_mag);
            rem_reg <= '0;
            neg_reg <= sum_reg[AGG_W-1];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.need_div = (agg_mode_reg == AGG_AVG) && (cnt_reg != '0);

    assign quo_signed = neg_reg ? -$signed(quo_reg[AGG_W-1:0]) : $signed(quo_reg[AGG_W-1:0]);

    always_comb
    begin
        unique case (agg_mode_reg)
            AGG_SUM:          agg_val = sum_reg;
            AGG_AVG:          agg_val = (cnt_reg != '0) ? quo_signed : sum_reg;
            AGG_MAX, AGG_MIN: agg_val = first_reg ? '0 : AGG_W'(ext_reg);
            default:          agg_val = '0;
        endcase
    end

    always_comb
    begin
        unique case (agg_mode_reg)
            AGG_ANY: cond = any_reg;
            AGG_ALL: cond = all_reg;
            AGG_SUM, AGG_AVG, AGG_MAX, AGG_MIN:
                     cond = rel(cmp_mode_reg, CMP_W'(agg_val), CMP_W'(threshold_reg));
            default: cond = 1'b0;
        endcase
    end

    assign alarm_latched_next = cmd.finish ? cond : alarm_latched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alarm_latched_reg <= 1'b0;
        else
            alarm_latched_reg <= alarm_latched_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            alarm_fire_reg      <= cond && !alarm_latched_reg;
            condition_reg       <= cond;
            aggregate_value_reg <= agg_val;
        end
    end

    assign alarm_fire      = alarm_fire_reg;
    assign condition       = condition_reg;
    assign aggregate_value = aggregate_value_reg;

endmodule
